>>> src/bsa_pkg.sv
`timescale 1ns / 1ps

package bsa_pkg;

  // bitmap word held in one memory entry
  localparam int WORD_BITS = 16;

  localparam int SLOTS_DEFAULT = 64;

  // reset value of the slot limit register
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

endpackage

>>> src/bsa_ram.sv
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = bsa_pkg::WORD_BITS,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bitmap_slot_allocator_top.sv
`timescale 1ns / 1ps

// bitmap slot allocator: hands out and takes back slots of a fixed pool of
// SLOTS entries. one input word is a request (action 0 allocates the lowest
// free slot, action 1 frees slot_index); each request gives exactly one
// result word with a status (ok, pool full, index out of range, slot already
// free), the granted slot on a good allocate (zero otherwise) and the count
// of slots in use afterwards. the taken flags live in one memory of 16-bit
// words with a registered read; every access is read, modify, write
// back. after reset a clearing pass writes every bitmap word once, and no
// request is taken until it ends; the slot_limit register may be written
// meanwhile. requests are handled one at a time. a full allocate or an
// out-of-range free goes straight to the done state, a free passes through
// RD_FREE, and an allocate passes through RD_ALLOC and then SCAN for each
// further bitmap word that the search for the next free slot has to read;
// that forward search through the memory, one word per cycle, sets the
// allocate time. the done state loads the result into the output register
// once it is free. the next request is accepted as soon as the result is in
// the output register, even while that result is still stalled. slot_limit
// values above SLOTS act as SLOTS and zero makes every allocate report pool
// full; lowering it does not stop frees of slots handed out before.

module bitmap_slot_allocator_top #(
  parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,

  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] slot_limit,

  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [5:0] slot_index,

  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [5:0] granted_slot,
  output logic [6:0] used_count
);

  localparam int WB     = bsa_pkg::WORD_BITS;
  localparam int WBW    = $clog2(WB);
  localparam int NWORDS = (SLOTS + WB - 1) / WB;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IW     = $clog2(SLOTS);       // slot number
  localparam int LW     = $clog2(SLOTS + 1);   // slot number or "none", also the use count
  localparam int CW     = (LW > 7) ? LW : 7;   // compare against the limit register
  localparam int XW     = (LW > 6) ? LW : 6;   // compare against the request index
  localparam int PW     = AW + WBW + 1;        // bit position in the pool, with room for SLOTS

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ALLOC,
    S_RD_FREE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state;
  logic [6:0]        limit;
  logic [LW-1:0]     lowest_free;
  logic [IW-1:0]     high_water;
  logic              any_allocated;
  logic [LW-1:0]     in_use;
  logic [AW-1:0]     cur_word;     // word under access, also the clear counter
  logic [WBW-1:0]    sel_bit;      // bit of the request slot inside cur_word
  logic [IW-1:0]     free_slot;
  bsa_pkg::status_t  res_status;
  logic [5:0]        res_granted;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WB-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WB-1:0]     ram_rdata;

  logic              in_take;
  logic              alloc_full;
  logic              free_bad;
  logic [WB-1:0]     bit_mask;
  logic [WB-1:0]     scan_word;
  logic              scan_found;
  logic [WBW-1:0]    scan_bit;
  logic              last_word;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // lowest free slot must lie below both the pool size and the limit
  assign alloc_full = (lowest_free >= LW'(SLOTS)) ||
                      (CW'(lowest_free) >= CW'(limit));

  assign free_bad = !any_allocated ||
                    (XW'(slot_index) > XW'(high_water)) ||
                    (XW'(slot_index) >= XW'(SLOTS));

  assign bit_mask  = WB'(1) << sel_bit;
  assign last_word = (cur_word == AW'(NWORDS - 1));

  // first word of an allocate already has the new slot marked
  assign scan_word = (state == S_RD_ALLOC) ? (ram_rdata | bit_mask) : ram_rdata;

  // lowest clear bit past the start point that is still inside the pool
  always_comb begin
    logic [PW-1:0] pos;
    scan_found = 1'b0;
    scan_bit   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      pos = PW'({cur_word, WBW'(b)});
      if (!scan_word[b] && (pos < PW'(SLOTS)) &&
          ((state != S_RD_ALLOC) || (WBW'(b) > sel_bit))) begin
        scan_found = 1'b1;
        scan_bit   = WBW'(b);
      end
    end
  end

  always_comb begin
    case (state)
      S_IDLE: begin
        if (action) begin
          ram_raddr = AW'(slot_index >> WBW);
        end else begin
          ram_raddr = AW'(lowest_free >> WBW);
        end
      end
      S_RD_ALLOC, S_SCAN: ram_raddr = cur_word + AW'(1);
      default:            ram_raddr = cur_word;
    endcase
  end

  always_comb begin
    ram_waddr = cur_word;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_RD_ALLOC: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | bit_mask;
      end
      S_RD_FREE: begin
        ram_we    = ram_rdata[sel_bit];
        ram_wdata = ram_rdata & ~bit_mask;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
      end
    endcase
  end

  // a write in RD_ALLOC / RD_FREE lands before any later read of the same
  // word is issued, so no forwarding path is needed
  bsa_ram #(
    .WIDTH (WB),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      limit         <= bsa_pkg::LIMIT_RESET;
      lowest_free   <= '0;
      high_water    <= '0;
      any_allocated <= 1'b0;
      in_use        <= '0;
      cur_word      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= slot_limit;
      end

      // word leaves with no new one loaded behind it
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          cur_word <= cur_word + AW'(1);
          if (last_word) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          res_granted <= '0;
          cur_word    <= ram_raddr;
          if (in_take) begin
            if (!action) begin
              sel_bit <= WBW'(lowest_free);
              if (alloc_full) begin
                res_status <= bsa_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_RD_ALLOC;
              end
            end else begin
              sel_bit   <= WBW'(slot_index);
              free_slot <= IW'(slot_index);
              if (free_bad) begin
                res_status <= bsa_pkg::ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_RD_FREE;
              end
            end
          end
        end

        S_RD_ALLOC, S_SCAN: begin
          if (state == S_RD_ALLOC) begin
            res_status    <= bsa_pkg::ST_OK;
            res_granted   <= 6'(lowest_free);
            any_allocated <= 1'b1;
            in_use        <= in_use + LW'(1);
            if (!any_allocated || (IW'(lowest_free) > high_water)) begin
              high_water <= IW'(lowest_free);
            end
          end
          if (scan_found) begin
            lowest_free <= LW'({cur_word, scan_bit});
            state       <= S_DONE;
          end else if (last_word) begin
            lowest_free <= LW'(SLOTS);
            state       <= S_DONE;
          end else begin
            cur_word <= cur_word + AW'(1);
            state    <= S_SCAN;
          end
        end

        S_RD_FREE: begin
          if (!ram_rdata[sel_bit]) begin
            res_status <= bsa_pkg::ST_ALREADY_FREE;
          end else begin
            res_status <= bsa_pkg::ST_OK;
            if (LW'(free_slot) < lowest_free) begin
              lowest_free <= LW'(free_slot);
            end
            if (in_use != '0) begin
              in_use <= in_use - LW'(1);
            end
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_slot <= res_granted;
            used_count   <= 7'(in_use);
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // counters never pass the pool size
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (in_use <= LW'(SLOTS)) && (lowest_free <= LW'(SLOTS)))
    else $error("slot counters beyond pool size");

  // use count moves by at most one per cycle
  a_use_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(in_use) |-> ((in_use == $past(in_use) + LW'(1)) ||
                          (in_use == $past(in_use) - LW'(1))))
    else $error("use count jumped");

  // nothing can be in use before the first allocation
  a_none_before_alloc: assert property (@(posedge clk) disable iff (rst)
    !any_allocated |-> (in_use == '0))
    else $error("slots in use without any allocation");

  // a granted slot lies below the limit that was in force
  a_grant_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_ALLOC) |-> (CW'(lowest_free) < CW'(limit)))
    else $error("allocation past the slot limit");
`endif

endmodule

>>> tb/sv/bitmap_slot_allocator_top_tb.sv
`timescale 1ns / 1ps

module bitmap_slot_allocator_top_tb;
  import bsa_pkg::*;

  localparam int POOL            = SLOTS_DEFAULT;
  localparam int RANDOM_REQUESTS = 750;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  // settle time before a limit write, longer than the longest allocate
  localparam int SETTLE_CYCLES   = 8;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // one result word as the block should report it
  typedef struct packed {
    status_t    st;
    logic [5:0] slot;
    logic [6:0] used;
  } reply_t;

  typedef enum logic { ROW_REQ, ROW_LIMIT } row_kind_t;

  // directed script row: a request (optionally with a hand-written reply) or a limit write
  typedef struct packed {
    row_kind_t  kind;
    logic       act;
    logic [5:0] idx;
    logic [6:0] lim;
    logic       pinned;
    reply_t     reply;
  } script_row_t;

  typedef enum logic [1:0] { PH_FILL, PH_MIX, PH_DRAIN } phase_kind_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] slot_limit;
  logic       in_valid;
  logic       in_stall;
  logic       action;
  logic [5:0] slot_index;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;
  logic [5:0] granted_slot;
  logic [6:0] used_count;

  // hand-written reply that travels with the request on the wire
  logic   pin_on;
  reply_t pin_res;

  // allocator mirror, updated at the edge where a request or a limit write is taken
  bit         slot_taken [POOL];
  bit   [6:0] free_hint;
  bit   [5:0] high_mark;
  bit         ever_granted;
  bit   [6:0] slots_used;
  bit   [6:0] cur_limit = LIMIT_RESET;

  reply_t replies_due[$];

  int errors;
  int cycle_count;
  int requests_taken;
  int limit_writes;
  int status_seen [4];
  int burst_left;
  int hold_left;
  bit hold_request;
  bit hold_done;

  bitmap_slot_allocator_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .slot_limit  (slot_limit),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .granted_slot(granted_slot),
    .used_count  (used_count)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mirror of one request: lowest free slot on allocate, range and bitmap checks on free
  task automatic predict_request(input logic act, input logic [5:0] idx, output reply_t r);
    logic [6:0] eff;
    int         k;
    // limits above the pool size act as the pool size
    eff = (cur_limit > POOL) ? 7'(POOL) : cur_limit;
    r.st = ST_OK;
    r.slot = '0;
    if (act == ACT_ALLOC) begin
      if (free_hint >= eff || free_hint >= POOL) begin
        r.st = ST_FULL;
      end else begin
        slot_taken[free_hint[5:0]] = 1'b1;
        if (!ever_granted || free_hint[5:0] > high_mark) high_mark = free_hint[5:0];
        ever_granted = 1'b1;
        r.slot = free_hint[5:0];
        // forward search runs over the whole pool, not only up to the limit
        k = free_hint + 1;
        while (k < POOL && slot_taken[k]) k++;
        free_hint = 7'(k);
        slots_used++;
      end
    end else begin
      // nothing handed out yet, or above the high-water mark
      if (!ever_granted || idx > high_mark) begin
        r.st = ST_RANGE;
      end else if (!slot_taken[idx]) begin
        r.st = ST_ALREADY_FREE;
      end else begin
        // slots at or above a lowered limit may still be freed
        slot_taken[idx] = 1'b0;
        if (idx < free_hint) free_hint = {1'b0, idx};
        if (slots_used > 0) slots_used--;
      end
    end
    r.used = slots_used;
  endtask

  // everything the block takes or gives is looked at on the rising edge
  always @(posedge clk) begin : monitor
    reply_t want;
    reply_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cur_limit = slot_limit;
        limit_writes++;
      end
      if (in_valid && !in_stall) begin
        predict_request(action, slot_index, want);
        // directed rows with a typed reply check that instead of the mirror
        if (pin_on) want = pin_res;
        replies_due.push_back(want);
        requests_taken++;
      end
      if (out_valid && !out_stall) begin
        got = {status_t'(status), granted_slot, used_count};
        status_seen[status]++;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected word: status %0d slot %0d used %0d",
                   $time, status, granted_slot, used_count);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected status %0d slot %0d used %0d,",
                     $time, want.st, want.slot, want.used);
            $display("%0t:           got status %0d slot %0d used %0d",
                     $time, status, granted_slot, used_count);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: one long hold-off on request, otherwise a stall pattern that
  // switches at random between none, light, heavy and alternating
  initial begin : receiver
    int mode;
    int mode_left;
    out_stall = 1'b0;
    mode = 0;
    mode_left = 64;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = 64;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 9) < 6);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  function automatic script_row_t req_row(logic act, logic [5:0] idx);
    script_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.act = act;
    row.idx = idx;
    return row;
  endfunction

  function automatic script_row_t pinned_row(logic act, logic [5:0] idx, status_t st,
                                             logic [5:0] slot, logic [6:0] used);
    script_row_t row;
    row = req_row(act, idx);
    row.pinned = 1'b1;
    row.reply = {st, slot, used};
    return row;
  endfunction

  function automatic script_row_t limit_row(logic [6:0] lim);
    script_row_t row;
    row = '0;
    row.kind = ROW_LIMIT;
    row.lim = lim;
    return row;
  endfunction

  // random slot that the mirror holds as taken, or any slot if none is
  function automatic logic [5:0] taken_slot();
    int start;
    int k;
    start = $urandom_range(0, POOL - 1);
    for (k = 0; k < POOL; k++) begin
      if (slot_taken[(start + k) % POOL]) return 6'((start + k) % POOL);
    end
    return 6'(start);
  endfunction

  // offer one request word and hold it until taken; valid stays high afterwards
  task automatic issue(input logic act, input logic [5:0] idx, input logic pin,
                       input reply_t res);
    in_valid = 1'b1;
    action = act;
    slot_index = idx;
    pin_on = pin;
    pin_res = res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // bursts of random length separated by random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // limit is only changed with nothing in flight
  task automatic write_limit(input logic [6:0] lim);
    in_valid = 1'b0;
    pin_on = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    slot_limit = lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    script_row_t script[$];
    int          rand_done;
    int          phase_no;
    int          phase_len;
    int          roll;
    int          alloc_cut;
    int          taken_cut;
    phase_kind_t kind;
    bit          no_gaps;
    logic        pick_act;
    logic [5:0]  pick_idx;
    logic [6:0]  lim;

    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ALLOC;
    slot_index = '0;
    cfg_valid = 1'b0;
    slot_limit = LIMIT_RESET;
    pin_on = 1'b0;
    pin_res = '0;

    // frees before anything was handed out are out of range
    script.push_back(pinned_row(ACT_FREE, 6'd0, ST_RANGE, 6'd0, 7'd0));
    script.push_back(pinned_row(ACT_FREE, 6'd63, ST_RANGE, 6'd0, 7'd0));
    script.push_back(pinned_row(ACT_ALLOC, 6'd63, ST_OK, 6'd0, 7'd1));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_OK, 6'd1, 7'd2));
    // above the high-water mark
    script.push_back(pinned_row(ACT_FREE, 6'd5, ST_RANGE, 6'd0, 7'd2));
    script.push_back(pinned_row(ACT_FREE, 6'd0, ST_OK, 6'd0, 7'd1));
    script.push_back(pinned_row(ACT_FREE, 6'd0, ST_ALREADY_FREE, 6'd0, 7'd1));
    // hint went back down to slot 0
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_OK, 6'd0, 7'd2));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_OK, 6'd2, 7'd3));
    // zero limit: every allocate is full
    script.push_back(limit_row(7'd0));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_FULL, 6'd0, 7'd3));
    // limit above the pool acts as the pool size
    script.push_back(limit_row(7'd127));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_OK, 6'd3, 7'd4));
    // slot 3 sits above a lowered limit and may still be freed
    script.push_back(limit_row(7'd2));
    script.push_back(pinned_row(ACT_FREE, 6'd3, ST_OK, 6'd0, 7'd3));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_FULL, 6'd0, 7'd3));
    script.push_back(limit_row(7'd64));
    script.push_back(pinned_row(ACT_ALLOC, 6'd0, ST_OK, 6'd3, 7'd4));
    script.push_back(pinned_row(ACT_FREE, 6'd63, ST_RANGE, 6'd0, 7'd4));
    script.push_back(req_row(ACT_FREE, 6'd2));
    script.push_back(req_row(ACT_ALLOC, 6'd42));
    script.push_back(req_row(ACT_FREE, 6'd1));
    script.push_back(req_row(ACT_ALLOC, 6'd21));

    // hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_LIMIT) write_limit(script[i].lim);
      else issue(script[i].act, script[i].idx, script[i].pinned, script[i].reply);
    end

    // random phases: fill, mixed traffic, drain, each with a fresh limit
    rand_done = 0;
    phase_no = 0;
    while (rand_done < RANDOM_REQUESTS) begin
      kind = phase_kind_t'(2'(phase_no % 3));
      case ($urandom_range(0, 7))
        0: lim = 7'd0;
        1: lim = 7'd1;
        2: lim = 7'($urandom_range(65, 127));
        3, 4: lim = 7'($urandom_range(1, 63));
        default: lim = 7'd64;
      endcase
      // fill phases lean toward the full pool so the high-water mark reaches the top
      if (kind == PH_FILL && $urandom_range(0, 1) == 1) lim = 7'd64;
      write_limit(lim);

      // second phase runs back to back against the long result hold-off
      no_gaps = (phase_no == 1) || ($urandom_range(0, 3) == 0);
      if (phase_no == 1) hold_request = 1'b1;

      case (kind)
        PH_FILL: begin
          alloc_cut = 85;
          taken_cut = 93;
        end
        PH_MIX: begin
          alloc_cut = 45;
          taken_cut = 85;
        end
        default: begin
          alloc_cut = 10;
          taken_cut = 90;
        end
      endcase

      phase_len = $urandom_range(20, 90);
      repeat (phase_len) begin
        if (!no_gaps) pace_sender();
        roll = $urandom_range(0, 99);
        pick_idx = 6'($urandom_range(0, POOL - 1));
        if (roll < alloc_cut) begin
          pick_act = ACT_ALLOC;
        end else begin
          pick_act = ACT_FREE;
          if (roll < taken_cut) pick_idx = taken_slot();
        end
        issue(pick_act, pick_idx, 1'b0, '0);
        rand_done++;
      end
      phase_no++;
    end

    in_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("%0d requests over %0d random phases, %0d limit writes", requests_taken,
             phase_no, limit_writes);
    $display("replies: %0d ok, %0d full, %0d out of range, %0d already free",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_ALREADY_FREE]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
